>>> src/bdwa_pkg.sv
// ----------------------------------------------------------------------------
// bdwa_pkg
// Shared codes, types and helpers of the binary delta window applier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdwa_pkg;

	localparam int INSTR_BYTES_DEF   = 4096;
	localparam int TARGET_WINDOW_DEF = 65536;
	localparam int SOURCE_BYTES_DEF  = 65536;

	localparam int CMD_QUEUE_DEPTH = 2;
	localparam int RES_QUEUE_DEPTH = 2;

	// Input operations.
	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_DELTA   = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BYTE       = 3'd1;
	localparam logic [2:0] ST_DONE       = 3'd2;
	localparam logic [2:0] ST_NEED_DELTA = 3'd3;
	localparam logic [2:0] ST_NEED_ADV   = 3'd4;
	localparam logic [2:0] ST_BAD        = 3'd5;
	localparam logic [2:0] ST_OVF        = 3'd6;

	// Stream phases.
	localparam logic [1:0] PH_MAGIC  = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_INSTR  = 2'd2;
	localparam logic [1:0] PH_EXEC   = 2'd3;

	// Instruction kinds from the top two bits of an instruction header.
	localparam logic [1:0] KIND_SOURCE = 2'd0;
	localparam logic [1:0] KIND_TARGET = 2'd1;
	localparam logic [1:0] KIND_NEW    = 2'd2;
	localparam logic [1:0] KIND_BAD    = 2'd3;

	// Configuration port.
	localparam int         CFG_AW         = 3;
	localparam logic [2:0] CFG_HAS_SOURCE = 3'd0;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data;
		logic [15:0] addr;
		logic        addr_ovf;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] target_byte;
		logic       last;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h53;
			2'd1:    b = 8'h56;
			2'd2:    b = 8'h4E;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Shifts in the seven payload bits of one varint byte.
	function automatic logic [31:0] varint_shift(input logic [31:0] acc, input logic [7:0] b);
		return {acc[24:0], b[6:0]};
	endfunction

endpackage

`default_nettype wire

>>> src/bdwa_ram.sv
// ----------------------------------------------------------------------------
// bdwa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> src/bdwa_fifo.sv
// ----------------------------------------------------------------------------
// bdwa_fifo
// Small register queue used between the front, the engine and the outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module bdwa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> src/bdwa_front.sv
// ----------------------------------------------------------------------------
// bdwa_front
// Input side: classifies each beat and queues it for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bdwa_front #(
	parameter int SOURCE_BYTES = bdwa_pkg::SOURCE_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire logic [1:0]     operation,
	input  wire logic [7:0]     data_byte,
	input  wire logic [15:0]    source_address,
	output logic                full,
	output logic                cmd_valid,
	output bdwa_pkg::cmd_t      cmd,
	input  wire logic           cmd_pop
);

	import bdwa_pkg::*;

	cmd_t                  cmd_in;
	logic [$bits(cmd_t)-1:0] q_bits;
	logic                  q_empty;

	always_comb begin
		cmd_in.op       = operation;
		cmd_in.data     = data_byte;
		cmd_in.addr     = source_address;
		cmd_in.addr_ovf = (32'(source_address) >= 32'(SOURCE_BYTES));
	end

	bdwa_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (q_bits),
		.empty (q_empty)
	);

	assign cmd       = cmd_t'(q_bits);
	assign cmd_valid = !q_empty;

endmodule

`default_nettype wire

>>> src/bdwa_engine.sv
// ----------------------------------------------------------------------------
// bdwa_engine
// Back end: stream parsing, instruction decode and byte reconstruction.
// ----------------------------------------------------------------------------
`default_nettype none

module bdwa_engine #(
	parameter int INSTR_BYTES   = bdwa_pkg::INSTR_BYTES_DEF,
	parameter int TARGET_WINDOW = bdwa_pkg::TARGET_WINDOW_DEF,
	parameter int SOURCE_BYTES  = bdwa_pkg::SOURCE_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           has_source,
	input  wire logic           cmd_valid,
	input  bdwa_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  wire logic           res_full,
	output logic                res_push,
	output bdwa_pkg::res_t      res
);

	import bdwa_pkg::*;

	localparam int IAW = $clog2(INSTR_BYTES);
	localparam int ICW = $clog2(INSTR_BYTES + 1);
	localparam int TAW = $clog2(TARGET_WINDOW);
	localparam int TCW = $clog2(TARGET_WINDOW + 1);
	localparam int SAW = $clog2(SOURCE_BYTES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HDR  = 3'd1;
	localparam logic [2:0] S_LEN  = 3'd2;
	localparam logic [2:0] S_OFF  = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;

	logic [2:0]     seq_q, seq_d;
	logic [1:0]     phase_q, phase_d;
	logic [1:0]     magic_q, magic_d;
	logic [2:0]     vi_q, vi_d;
	logic [31:0]    acc_q, acc_d;
	logic [31:0]    svo_q, svo_d, svl_q, svl_d, tvl_q, tvl_d, il_q, il_d, ndr_q, ndr_d;
	logic [ICW-1:0] fill_q, fill_d, ip_q, ip_d;
	logic [1:0]     kind_q, kind_d, pkind_q, pkind_d;
	logic [31:0]    cur_len_q, cur_len_d, cur_off_q, cur_off_d;
	logic [31:0]    plen_q, plen_d, poff_q, poff_d;
	logic [TCW-1:0] written_q, written_d;
	logic           err_q, err_d;
	logic           pend_adv_q, pend_adv_d;
	logic [7:0]     pend_byte_q, pend_byte_d;

	logic           src_we, tgt_we, ins_we;
	logic [SAW-1:0] src_waddr, src_raddr;
	logic [TAW-1:0] tgt_waddr, tgt_raddr;
	logic [IAW-1:0] ins_waddr, ins_raddr;
	logic [7:0]     src_wdata, tgt_wdata, ins_wdata;
	logic [7:0]     src_rdata, tgt_rdata, ins_rdata;
	logic           src_fwd_q, tgt_fwd_q, ins_fwd_q;
	logic [7:0]     src_fwd_data_q, tgt_fwd_data_q, ins_fwd_data_q;
	logic [7:0]     src_byte, tgt_byte, ins_byte;

	logic           fin;
	logic [2:0]     fin_st;
	logic [2:0]     st;
	logic [7:0]     b;
	logic [31:0]    newacc_s, newacc_i, ip32, addr32;
	logic [32:0]    sum_w, sum_src;
	logic           is_new;

	// The read port of each store always looks at the next offset, so the
	// byte is ready in the following cycle; a same-cycle write to that entry is
	// forwarded around the read-first RAM.
	assign src_byte = src_fwd_q ? src_fwd_data_q : src_rdata;
	assign tgt_byte = tgt_fwd_q ? tgt_fwd_data_q : tgt_rdata;
	assign ins_byte = ins_fwd_q ? ins_fwd_data_q : ins_rdata;

	assign src_raddr = cur_off_d[SAW-1:0];
	assign tgt_raddr = cur_off_d[TAW-1:0];
	assign ins_raddr = ip_d[IAW-1:0];

	always_comb begin
		seq_d       = seq_q;
		phase_d     = phase_q;
		magic_d     = magic_q;
		vi_d        = vi_q;
		acc_d       = acc_q;
		svo_d       = svo_q;
		svl_d       = svl_q;
		tvl_d       = tvl_q;
		il_d        = il_q;
		ndr_d       = ndr_q;
		fill_d      = fill_q;
		ip_d        = ip_q;
		kind_d      = kind_q;
		pkind_d     = pkind_q;
		cur_len_d   = cur_len_q;
		cur_off_d   = cur_off_q;
		plen_d      = plen_q;
		poff_d      = poff_q;
		written_d   = written_q;
		err_d       = err_q;
		pend_adv_d  = pend_adv_q;
		pend_byte_d = pend_byte_q;

		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		st       = ST_OK;
		fin      = 1'b0;
		fin_st   = ST_OK;
		b        = cmd.data;
		is_new   = (kind_q == KIND_NEW);

		addr32    = 32'(cmd.addr);
		src_we    = 1'b0;
		src_waddr = addr32[SAW-1:0];
		src_wdata = cmd.data;
		tgt_we    = 1'b0;
		tgt_waddr = written_q[TAW-1:0];
		tgt_wdata = cmd.data;
		ins_we    = 1'b0;
		ins_waddr = fill_q[IAW-1:0];
		ins_wdata = cmd.data;

		newacc_s = varint_shift(acc_q, cmd.data);
		newacc_i = varint_shift(acc_q, ins_byte);
		ip32     = 32'(ip_q);
		sum_w    = {1'b0, 32'(written_q)} + {1'b0, plen_q};
		sum_src  = {1'b0, poff_q} + {1'b0, plen_q};

		case (seq_q)
			S_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop  = 1'b1;
					res_push = 1'b1;
					case (cmd.op)
						OP_LOAD: begin
							if (cmd.addr_ovf) begin
								st = ST_OVF;
							end else begin
								src_we = 1'b1;
							end
						end
						OP_RESTART: begin
							phase_d   = PH_MAGIC;
							magic_d   = '0;
							vi_d      = '0;
							acc_d     = '0;
							svo_d     = '0;
							svl_d     = '0;
							tvl_d     = '0;
							il_d      = '0;
							ndr_d     = '0;
							fill_d    = '0;
							ip_d      = '0;
							kind_d    = '0;
							cur_len_d = '0;
							cur_off_d = '0;
							written_d = '0;
							err_d     = 1'b0;
						end
						default: begin
							if (err_q) begin
								st = ST_BAD;
							end else if (phase_q != PH_EXEC) begin
								if (cmd.op == OP_ADVANCE) begin
									st = ST_NEED_DELTA;
								end else if (phase_q == PH_MAGIC) begin
									if (cmd.data != magic_byte(magic_q)) begin
										st = ST_BAD;
									end else if (magic_q == 2'd3) begin
										magic_d = '0;
										phase_d = PH_HEADER;
									end else begin
										magic_d = magic_q + 1'b1;
									end
								end else if (phase_q == PH_HEADER) begin
									if (acc_q[31:25] != '0) begin
										st = ST_OVF;
									end else if (cmd.data[7]) begin
										acc_d = newacc_s;
									end else begin
										acc_d = '0;
										case (vi_q)
											3'd0:    svo_d = newacc_s;
											3'd1:    svl_d = newacc_s;
											3'd2:    tvl_d = newacc_s;
											3'd3:    il_d  = newacc_s;
											default: ndr_d = newacc_s;
										endcase
										if (vi_q != 3'd4) begin
											vi_d = vi_q + 1'b1;
										end else begin
											vi_d = '0;
											if (il_q > 32'(INSTR_BYTES)) begin
												st = ST_OVF;
											end else if (tvl_q > 32'(TARGET_WINDOW)) begin
												st = ST_OVF;
											end else if ({1'b0, svo_q} + {1'b0, svl_q} >
													33'(SOURCE_BYTES)) begin
												st = ST_OVF;
											end else begin
												fill_d    = '0;
												ip_d      = '0;
												written_d = '0;
												cur_len_d = '0;
												kind_d    = '0;
												if (il_q == '0) begin
													phase_d    = PH_EXEC;
													pend_adv_d = 1'b0;
													seq_d      = S_HDR;
													res_push   = 1'b0;
												end else begin
													phase_d = PH_INSTR;
												end
											end
										end
									end
								end else begin
									ins_we = 1'b1;
									fill_d = fill_q + 1'b1;
									if (32'(fill_q) + 32'd1 >= il_q) begin
										phase_d    = PH_EXEC;
										pend_adv_d = 1'b0;
										seq_d      = S_HDR;
										res_push   = 1'b0;
									end
								end
							end else if (cmd.op == OP_DELTA && !is_new) begin
								st = ST_NEED_ADV;
							end else if (cmd.op == OP_ADVANCE && is_new) begin
								st = ST_NEED_DELTA;
							end else begin
								if (is_new) begin
									b = cmd.data;
								end else begin
									b = (kind_q == KIND_SOURCE) ? src_byte : tgt_byte;
									cur_off_d = cur_off_q + 32'd1;
								end
								tgt_we    = 1'b1;
								tgt_wdata = b;
								written_d = written_q + 1'b1;
								cur_len_d = cur_len_q - 32'd1;
								st        = ST_BYTE;
								if (cur_len_q == 32'd1) begin
									pend_byte_d = b;
									pend_adv_d  = 1'b1;
									seq_d       = S_HDR;
									res_push    = 1'b0;
								end
							end
						end
					endcase
					res.status      = st;
					res.target_byte = (st == ST_BYTE) ? b : 8'h00;
					res.last        = 1'b0;
					if ((st == ST_BAD || st == ST_OVF) &&
							(cmd.op == OP_DELTA || cmd.op == OP_ADVANCE)) begin
						err_d = 1'b1;
					end
				end
			end
			S_HDR: begin
				if (!res_full) begin
					if (ip32 >= il_q) begin
						fin = 1'b1;
						if (32'(written_q) != tvl_q || ndr_q != '0) begin
							fin_st = ST_BAD;
						end else begin
							fin_st  = ST_DONE;
							phase_d = PH_HEADER;
							vi_d    = '0;
							acc_d   = '0;
						end
					end else begin
						ip_d    = ip_q + 1'b1;
						pkind_d = ins_byte[7:6];
						acc_d   = '0;
						if (ins_byte[5:0] == '0) begin
							seq_d = S_LEN;
						end else begin
							plen_d = 32'(ins_byte[5:0]);
							if (ins_byte[7:6] == KIND_BAD) begin
								fin    = 1'b1;
								fin_st = ST_BAD;
							end else if (ins_byte[7:6] == KIND_NEW) begin
								poff_d = '0;
								seq_d  = S_CHK;
							end else begin
								seq_d = S_OFF;
							end
						end
					end
				end
			end
			S_LEN, S_OFF: begin
				if (!res_full) begin
					if (acc_q[31:25] != '0) begin
						fin    = 1'b1;
						fin_st = ST_OVF;
					end else if (ip32 >= il_q) begin
						fin    = 1'b1;
						fin_st = ST_BAD;
					end else begin
						ip_d  = ip_q + 1'b1;
						acc_d = newacc_i;
						if (!ins_byte[7]) begin
							acc_d = '0;
							if (seq_q == S_OFF) begin
								poff_d = newacc_i;
								seq_d  = S_CHK;
							end else begin
								plen_d = newacc_i;
								if (pkind_q == KIND_BAD) begin
									fin    = 1'b1;
									fin_st = ST_BAD;
								end else if (pkind_q == KIND_NEW) begin
									poff_d = '0;
									seq_d  = S_CHK;
								end else begin
									seq_d = S_OFF;
								end
							end
						end
					end
				end
			end
			S_CHK: begin
				if (!res_full) begin
					if (sum_w > {1'b0, tvl_q}) begin
						fin    = 1'b1;
						fin_st = ST_BAD;
					end else begin
						case (pkind_q)
							KIND_SOURCE: begin
								if (!has_source || sum_src > {1'b0, svl_q}) begin
									fin    = 1'b1;
									fin_st = ST_BAD;
								end else begin
									cur_off_d = svo_q + poff_q;
								end
							end
							KIND_TARGET: begin
								if (plen_q == '0 || poff_q >= 32'(written_q)) begin
									fin    = 1'b1;
									fin_st = ST_BAD;
								end else begin
									cur_off_d = poff_q;
								end
							end
							default: begin
								if (plen_q > ndr_q) begin
									fin    = 1'b1;
									fin_st = ST_BAD;
								end else begin
									ndr_d     = ndr_q - plen_q;
									cur_off_d = '0;
								end
							end
						endcase
						if (!fin) begin
							kind_d    = pkind_q;
							cur_len_d = plen_q;
							if (plen_q == '0) begin
								seq_d = S_HDR;
							end else begin
								fin    = 1'b1;
								fin_st = ST_OK;
							end
						end
					end
				end
			end
			default: begin
				seq_d = S_IDLE;
			end
		endcase

		// End of an instruction search: the answer of the beat that started it.
		if (fin) begin
			seq_d    = S_IDLE;
			res_push = 1'b1;
			if (pend_adv_q && (fin_st == ST_OK || fin_st == ST_DONE)) begin
				res.status      = ST_BYTE;
				res.target_byte = pend_byte_q;
				res.last        = (fin_st == ST_DONE);
			end else begin
				res.status = fin_st;
			end
			if (fin_st == ST_BAD || fin_st == ST_OVF) begin
				err_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_IDLE;
			phase_q     <= PH_MAGIC;
			magic_q     <= '0;
			vi_q        <= '0;
			acc_q       <= '0;
			svo_q       <= '0;
			svl_q       <= '0;
			tvl_q       <= '0;
			il_q        <= '0;
			ndr_q       <= '0;
			fill_q      <= '0;
			ip_q        <= '0;
			kind_q      <= '0;
			pkind_q     <= '0;
			cur_len_q   <= '0;
			cur_off_q   <= '0;
			plen_q      <= '0;
			poff_q      <= '0;
			written_q   <= '0;
			err_q       <= 1'b0;
			pend_adv_q  <= 1'b0;
			pend_byte_q <= '0;
			src_fwd_q   <= 1'b0;
			tgt_fwd_q   <= 1'b0;
			ins_fwd_q   <= 1'b0;
		end else begin
			seq_q       <= seq_d;
			phase_q     <= phase_d;
			magic_q     <= magic_d;
			vi_q        <= vi_d;
			acc_q       <= acc_d;
			svo_q       <= svo_d;
			svl_q       <= svl_d;
			tvl_q       <= tvl_d;
			il_q        <= il_d;
			ndr_q       <= ndr_d;
			fill_q      <= fill_d;
			ip_q        <= ip_d;
			kind_q      <= kind_d;
			pkind_q     <= pkind_d;
			cur_len_q   <= cur_len_d;
			cur_off_q   <= cur_off_d;
			plen_q      <= plen_d;
			poff_q      <= poff_d;
			written_q   <= written_d;
			err_q       <= err_d;
			pend_adv_q  <= pend_adv_d;
			pend_byte_q <= pend_byte_d;
			src_fwd_q   <= src_we && (src_waddr == src_raddr);
			tgt_fwd_q   <= tgt_we && (tgt_waddr == tgt_raddr);
			ins_fwd_q   <= ins_we && (ins_waddr == ins_raddr);
		end
	end

	always_ff @(posedge clk) begin
		src_fwd_data_q <= src_wdata;
		tgt_fwd_data_q <= tgt_wdata;
		ins_fwd_data_q <= ins_wdata;
	end

	bdwa_ram #(.WIDTH(8), .DEPTH(SOURCE_BYTES)) u_source_store (
		.clk  (clk),
		.we   (src_we),
		.waddr(src_waddr),
		.wdata(src_wdata),
		.raddr(src_raddr),
		.rdata(src_rdata)
	);

	bdwa_ram #(.WIDTH(8), .DEPTH(TARGET_WINDOW)) u_target_store (
		.clk  (clk),
		.we   (tgt_we),
		.waddr(tgt_waddr),
		.wdata(tgt_wdata),
		.raddr(tgt_raddr),
		.rdata(tgt_rdata)
	);

	bdwa_ram #(.WIDTH(8), .DEPTH(INSTR_BYTES)) u_instr_store (
		.clk  (clk),
		.we   (ins_we),
		.waddr(ins_waddr),
		.wdata(ins_wdata),
		.raddr(ins_raddr),
		.rdata(ins_rdata)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (seq_q == S_IDLE))
		else $error("command taken during instruction decode");

	a_copy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_IDLE && phase_q == PH_EXEC && !err_q) |-> (cur_len_q != '0))
		else $error("executing with no copy in progress");

	a_written_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXEC && !err_q) |-> (32'(written_q) <= tvl_q))
		else $error("target bytes beyond the target view");

endmodule

`default_nettype wire

>>> src/binary_delta_window_applier.sv
// ----------------------------------------------------------------------------
// binary_delta_window_applier
// Rebuilds a target file from a source file and an svndiff version-0 delta.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle on its input queue while the queue
// is not full, and gives one result beat per input beat, in order. An accepted
// beat is registered in the command queue before the engine sees it. Loads,
// stream bytes and copy advances are each handled in the engine's idle state,
// and their result is registered in the output queue before it can be popped.
// When the instruction buffer fills and after the last byte of every copy, the
// engine decodes instructions from its instruction store at one instruction
// byte per cycle (one read port) while the output queue has room, checks each
// instruction, and makes an end-of-window check when no instruction is left.
// The result of that beat enters the output queue only when the decode ends;
// further input beats queue up in the meantime. The stores need no clearing
// after reset.
`default_nettype none

module binary_delta_window_applier #(
	parameter int INSTR_BYTES   = bdwa_pkg::INSTR_BYTES_DEF,
	parameter int TARGET_WINDOW = bdwa_pkg::TARGET_WINDOW_DEF,
	parameter int SOURCE_BYTES  = bdwa_pkg::SOURCE_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bdwa_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [1:0]                  operation,
	input  wire logic [7:0]                  data_byte,
	input  wire logic [15:0]                 source_address,
	output logic                             empty,
	input  wire logic                        pop,
	output logic      [2:0]                  status,
	output logic      [7:0]                  target_byte,
	output logic                             last_of_window
);

	import bdwa_pkg::*;

	logic                    has_source_q;
	logic                    cmd_valid, cmd_pop;
	cmd_t                    cmd;
	logic                    res_full, res_push;
	res_t                    res, res_out;
	logic [$bits(res_t)-1:0] res_bits;

	assign pready = 1'b1;
	assign prdata = (paddr == CFG_HAS_SOURCE) ? {31'b0, has_source_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_source_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr == CFG_HAS_SOURCE) begin
			has_source_q <= pwdata[0];
		end
	end

	bdwa_front #(.SOURCE_BYTES(SOURCE_BYTES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.operation     (operation),
		.data_byte     (data_byte),
		.source_address(source_address),
		.full          (full),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	bdwa_engine #(
		.INSTR_BYTES  (INSTR_BYTES),
		.TARGET_WINDOW(TARGET_WINDOW),
		.SOURCE_BYTES (SOURCE_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.has_source(has_source_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	bdwa_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign res_out        = res_t'(res_bits);
	assign status         = res_out.status;
	assign target_byte    = res_out.target_byte;
	assign last_of_window = res_out.last;

endmodule

`default_nettype wire
